[sv/tmrq_pkg.sv]
package tmrq_pkg;

    typedef struct packed {
        logic [7:0]  handle;
        logic [15:0] tag;
        logic [7:0]  repeats;
        logic [15:0] interval;
        logic [31:0] shown_at;
    } t_entry;

    localparam logic [2:0] CMD_NEW    = 3'd0;
    localparam logic [2:0] CMD_CLEAR  = 3'd1;
    localparam logic [2:0] CMD_END    = 3'd2;
    localparam logic [2:0] CMD_EDGE   = 3'd3;
    localparam logic [2:0] CMD_RETRY  = 3'd4;

    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_SWAP   = 3'd2;
    localparam logic [2:0] ACT_ABORT  = 3'd3;
    localparam logic [2:0] ACT_ARM    = 3'd4;

    localparam logic [7:0] REP_FOREVER = 8'hFF;
    localparam logic [7:0] REP_ONE     = 8'd1;

endpackage

[sv/tagged_message_rotation_queue.sv]
// Commands that touch only the showing message pass from idle to the done state and on
// to the output register; a queue walk alternates read and write-back for each waiting
// entry, then ends, appends where needed and finishes in done. One beat at a time; the
// single read port of the entry memory gives one read, one write-back per entry.
// Reset (i_rst_n low, synchronous): queue empty, nothing showing, max_queue_len = 8.
// Entry memory contents are not cleared; only entries below the count are ever read.
module tagged_message_rotation_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [3:0]                          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [2:0]                          i_cmd,
    input  logic [7:0]                          i_msg_handle,
    input  logic [15:0]                         i_msg_tag,
    input  logic                                i_msg_empty,
    input  logic signed [7:0]                   i_repeat_count,
    input  logic [15:0]                         i_interval_ms,
    input  logic [31:0]                         i_now_ms,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_action,
    output logic [7:0]                          o_shown_handle,
    output logic                                o_dropped,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    o_queue_count
);
    import tmrq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int XW = CW + 4;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_WR, S_END, S_APPEND, S_DONE} t_state;
    // Walk flavor: tag lookup for a new message, clear by tag, pick next eligible
    typedef enum logic [1:0] {M_TAG, M_CLR, M_EVAL} t_mode;

    t_state r_state;
    t_mode  r_mode;

    // Latched beat
    logic [7:0]  r_handle;
    logic [15:0] r_tag;
    logic        r_empty;
    logic [7:0]  r_rep;
    logic [15:0] r_iv;
    logic [31:0] r_now;

    // Showing message
    logic        r_show_valid;
    logic [7:0]  r_show_handle;
    logic [15:0] r_show_tag;
    logic [7:0]  r_show_rep;
    logic [15:0] r_show_iv;

    logic [CW-1:0] r_total;
    logic [CW-1:0] r_rd;
    logic [CW-1:0] r_wr;
    logic          r_found;
    logic [3:0]    r_max;

    // Result under construction
    logic [2:0]  r_action;
    logic [7:0]  r_shown;
    logic        r_dropped;

    // Output register
    logic          r_out_valid;
    logic [2:0]    r_o_action;
    logic [7:0]    r_o_shown;
    logic          r_o_dropped;
    logic [CW-1:0] r_o_count;

    // Memory port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;

    tmrq_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic in_fire;
    logic out_free;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Scroll end: decide keep and the decremented repeat count of the showing message
    logic       keep;
    logic [7:0] rep_dec;
    assign keep    = (r_show_rep == REP_FOREVER) || ($signed(r_show_rep) > 8'sd1);
    assign rep_dec = (r_show_rep == REP_FOREVER) ? REP_FOREVER : r_show_rep - 8'd1;

    // Per-entry decision during the walk
    logic tag_eq;
    logic elapsed;
    logic hit;
    logic drop;
    assign tag_eq  = (mem_rdata.tag == r_tag);
    assign elapsed = (r_now - mem_rdata.shown_at) >= {16'd0, mem_rdata.interval};

    always_comb begin
        hit  = 1'b0;
        drop = 1'b0;
        case (r_mode)
            M_CLR: begin
                drop = tag_eq;
            end
            M_TAG: begin
                hit  = !r_found && tag_eq;
                drop = hit && r_empty;
            end
            M_EVAL: begin
                hit  = !r_found && elapsed;
                drop = hit;
            end
            default: begin
                hit  = 1'b0;
                drop = 1'b0;
            end
        endcase
    end

    logic append_ok;
    assign append_ok = (XW'(r_total) < XW'(r_max)) && (r_total < DEPTH_C);

    // Single write port: requeue at accept, write-back during the walk, append
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wr[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = r_rd[AW-1:0];
        case (r_state)
            S_IDLE: begin
                mem_waddr = r_total[AW-1:0];
                mem_wdata = '{r_show_handle, r_show_tag, rep_dec, r_show_iv, i_now_ms};
                mem_we    = in_fire && (i_cmd == CMD_END) && r_show_valid && keep
                            && !((r_total == '0) && (r_show_iv == '0))
                            && (r_total < DEPTH_C);
            end
            S_WR: begin
                mem_we = !drop;
                if (r_mode == M_TAG && hit) begin
                    mem_wdata = '{r_handle, r_tag, r_rep, r_iv, 32'd0};
                end
            end
            S_APPEND: begin
                mem_waddr = r_total[AW-1:0];
                mem_wdata = '{r_handle, r_tag, r_rep, r_iv, 32'd0};
                mem_we    = append_ok;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mode        <= M_TAG;
            r_show_valid  <= 1'b0;
            r_show_handle <= '0;
            r_show_tag    <= '0;
            r_show_rep    <= '0;
            r_show_iv     <= '0;
            r_total       <= '0;
            r_rd          <= '0;
            r_wr          <= '0;
            r_found       <= 1'b0;
            r_max         <= 4'd8;
            r_out_valid   <= 1'b0;
            r_action      <= ACT_NONE;
            r_shown       <= '0;
            r_dropped     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            // Drop the result once taken; the done state reloads it itself
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_handle  <= i_msg_handle;
                        r_tag     <= i_msg_tag;
                        r_empty   <= i_msg_empty;
                        r_rep     <= i_repeat_count;
                        r_iv      <= i_interval_ms;
                        r_now     <= i_now_ms;
                        r_rd      <= '0;
                        r_wr      <= '0;
                        r_found   <= 1'b0;
                        r_dropped <= 1'b0;
                        case (i_cmd)
                            CMD_NEW: begin
                                if (!r_show_valid) begin
                                    r_show_valid  <= 1'b1;
                                    r_show_handle <= i_msg_handle;
                                    r_show_tag    <= i_msg_tag;
                                    r_show_rep    <= i_repeat_count;
                                    r_show_iv     <= i_interval_ms;
                                    r_action      <= ACT_START;
                                    r_shown       <= i_msg_handle;
                                    r_state       <= S_DONE;
                                end else if (i_msg_tag != '0 && i_msg_tag == r_show_tag) begin
                                    if (!i_msg_empty) begin
                                        r_show_handle <= i_msg_handle;
                                        r_show_rep    <= i_repeat_count;
                                        r_show_iv     <= i_interval_ms;
                                        r_action      <= ACT_SWAP;
                                        r_shown       <= i_msg_handle;
                                    end else begin
                                        r_show_valid <= 1'b0;
                                        r_action     <= ACT_ABORT;
                                        r_shown      <= '0;
                                    end
                                    r_state <= S_DONE;
                                end else if (i_msg_tag != '0) begin
                                    r_action <= ACT_NONE;
                                    r_shown  <= '0;
                                    r_mode   <= M_TAG;
                                    r_state  <= S_RD;
                                end else begin
                                    r_action <= ACT_NONE;
                                    r_shown  <= '0;
                                    r_state  <= S_APPEND;
                                end
                            end
                            CMD_CLEAR: begin
                                if (r_show_valid && r_show_tag == i_msg_tag) begin
                                    r_show_rep <= REP_ONE;
                                    r_action   <= ACT_ABORT;
                                end else begin
                                    r_action   <= ACT_NONE;
                                end
                                r_shown <= '0;
                                r_mode  <= M_CLR;
                                r_state <= S_RD;
                            end
                            CMD_END: begin
                                if (r_show_valid && keep && r_total == '0
                                        && r_show_iv == '0) begin
                                    // Restart in place, nothing else waits
                                    r_show_rep <= rep_dec;
                                    r_action   <= ACT_START;
                                    r_shown    <= r_show_handle;
                                    r_state    <= S_DONE;
                                end else begin
                                    if (r_show_valid && keep && r_total < DEPTH_C) begin
                                        r_total <= r_total + 1'b1;
                                    end
                                    r_show_valid <= 1'b0;
                                    r_action     <= ACT_NONE;
                                    r_shown      <= '0;
                                    r_mode       <= M_EVAL;
                                    r_state      <= S_RD;
                                end
                            end
                            CMD_EDGE: begin
                                r_action <= ACT_ABORT;
                                r_shown  <= '0;
                                r_state  <= S_DONE;
                            end
                            CMD_RETRY: begin
                                r_action <= ACT_NONE;
                                r_shown  <= '0;
                                if (!r_show_valid) begin
                                    r_mode  <= M_EVAL;
                                    r_state <= S_RD;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: begin
                                r_action <= ACT_NONE;
                                r_shown  <= '0;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= (r_rd == r_total) ? S_END : S_WR;
                end
                S_WR: begin
                    if (hit) begin
                        r_found <= 1'b1;
                    end
                    if (r_mode == M_EVAL && hit) begin
                        r_show_valid  <= 1'b1;
                        r_show_handle <= mem_rdata.handle;
                        r_show_tag    <= mem_rdata.tag;
                        r_show_rep    <= mem_rdata.repeats;
                        r_show_iv     <= mem_rdata.interval;
                        r_shown       <= mem_rdata.handle;
                    end
                    if (!drop) begin
                        r_wr <= r_wr + 1'b1;
                    end
                    r_rd    <= r_rd + 1'b1;
                    r_state <= S_RD;
                end
                S_END: begin
                    r_total <= r_wr;
                    if (r_mode == M_TAG && !r_found) begin
                        r_state <= S_APPEND;
                    end else begin
                        r_state <= S_DONE;
                    end
                    if (r_mode == M_EVAL) begin
                        if (r_found) begin
                            r_action <= ACT_START;
                        end else if (r_total == '0) begin
                            r_action <= ACT_NONE;
                        end else begin
                            r_action <= ACT_ARM;
                        end
                    end
                end
                S_APPEND: begin
                    if (append_ok) begin
                        r_total <= r_total + 1'b1;
                    end else begin
                        r_dropped <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hold the result until the output register frees up
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_action  <= r_action;
                        r_o_shown   <= r_shown;
                        r_o_dropped <= r_dropped;
                        r_o_count   <= r_total;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_action       = r_o_action;
    assign o_shown_handle = r_o_shown;
    assign o_dropped      = r_o_dropped;
    assign o_queue_count  = r_o_count;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= DEPTH_C)
        else $error("queue count above depth");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside done state");

    a_pick_removes_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END && r_mode == M_EVAL && r_found)
        |=> r_total == $past(r_total) - 1'b1)
        else $error("picked entry not removed");

    a_append_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPEND && mem_we) |-> (r_total < DEPTH_C))
        else $error("append past depth");
`endif

endmodule

[sv/tmrq_mem.sv]
module tmrq_mem #(
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  tmrq_pkg::t_entry          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output tmrq_pkg::t_entry          o_rdata
);
    import tmrq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[test/tb_tagged_message_rotation_queue.sv]
module tb_tagged_message_rotation_queue;
    import tmrq_pkg::*;

    localparam int DEPTH = 16;
    localparam int N_RANDOM = 930;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_cmd;
    logic [7:0]  i_msg_handle;
    logic [15:0] i_msg_tag;
    logic        i_msg_empty;
    logic signed [7:0] i_repeat_count;
    logic [15:0] i_interval_ms;
    logic [31:0] i_now_ms;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_action;
    logic [7:0]  o_shown_handle;
    logic        o_dropped;
    logic [4:0]  o_queue_count;

    tagged_message_rotation_queue #(.QUEUE_DEPTH(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_cmd(i_cmd), .i_msg_handle(i_msg_handle), .i_msg_tag(i_msg_tag),
        .i_msg_empty(i_msg_empty), .i_repeat_count(i_repeat_count),
        .i_interval_ms(i_interval_ms), .i_now_ms(i_now_ms),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_action(o_action), .o_shown_handle(o_shown_handle),
        .o_dropped(o_dropped), .o_queue_count(o_queue_count)
    );

    typedef struct {
        logic [2:0]  cmd;
        logic [7:0]  handle;
        logic [15:0] tag;
        logic        empty;
        logic [7:0]  repeats;
        logic [15:0] interval;
        logic [31:0] now;
    } msg_beat_t;

    typedef struct {
        logic [2:0] action;
        logic [7:0] handle;
        logic       dropped;
        logic [4:0] count;
    } sched_result_t;

    // directed row: beat plus optional hand-typed result
    typedef struct {
        msg_beat_t     beat;
        bit            typed;
        sched_result_t res;
    } row_t;

    // scheduler shadow state
    t_entry      wq [DEPTH];
    int          wq_total;
    bit          sh_valid;
    logic [7:0]  sh_handle;
    logic [15:0] sh_tag;
    logic [7:0]  sh_repeats;
    logic [15:0] sh_interval;
    int          queue_limit;

    sched_result_t pending_results[$];
    // hand-typed expectations, one entry per accepted beat
    bit            typed_q[$];
    sched_result_t typed_res_q[$];
    int  errors;
    int  n_beats;
    int  n_results;
    bit  stall_long;
    int  limit_hits [int];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("timeout at %0t", $time);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void drop_entry(int pos);
        for (int k = pos; k + 1 < wq_total; k++) wq[k] = wq[k + 1];
        wq_total--;
    endfunction

    function automatic t_entry make_entry(logic [7:0] h, logic [15:0] t, logic [7:0] r,
                                          logic [15:0] iv, logic [31:0] at);
        t_entry e;
        e.handle = h; e.tag = t; e.repeats = r; e.interval = iv; e.shown_at = at;
        return e;
    endfunction

    // when nothing shows and entries wait, pick the first eligible one, else ask for a retry
    function automatic void pick_next(logic [31:0] now, ref sched_result_t r);
        logic [31:0] age;
        if (sh_valid || wq_total == 0) return;
        for (int i = 0; i < wq_total; i++) begin
            age = now - wq[i].shown_at;
            if (age >= {16'd0, wq[i].interval}) begin
                sh_valid = 1'b1;
                sh_handle = wq[i].handle;
                sh_tag = wq[i].tag;
                sh_repeats = wq[i].repeats;
                sh_interval = wq[i].interval;
                drop_entry(i);
                r.action = ACT_START;
                r.handle = sh_handle;
                return;
            end
        end
        r.action = ACT_ARM;
    endfunction

    function automatic sched_result_t schedule(msg_beat_t b);
        sched_result_t r;
        bit done;
        bit restarted;
        int rep;
        int i;
        r = '{ACT_NONE, 8'd0, 1'b0, 5'd0};
        done = 1'b0;
        restarted = 1'b0;
        case (b.cmd)
            CMD_NEW: begin
                if (!sh_valid) begin
                    sh_valid = 1'b1; sh_handle = b.handle; sh_tag = b.tag;
                    sh_repeats = b.repeats; sh_interval = b.interval;
                    r.action = ACT_START; r.handle = b.handle; done = 1'b1;
                end else if (b.tag != 0 && b.tag == sh_tag) begin
                    if (!b.empty) begin
                        sh_handle = b.handle; sh_repeats = b.repeats;
                        sh_interval = b.interval;
                        r.action = ACT_SWAP; r.handle = b.handle;
                    end else begin
                        sh_valid = 1'b0;
                        r.action = ACT_ABORT;
                    end
                    done = 1'b1;
                end else if (b.tag != 0) begin
                    for (i = 0; i < wq_total; i++) begin
                        if (wq[i].tag == b.tag) begin
                            if (!b.empty)
                                wq[i] = make_entry(b.handle, b.tag, b.repeats, b.interval, 0);
                            else
                                drop_entry(i);
                            done = 1'b1;
                            break;
                        end
                    end
                end
                if (!done) begin
                    if (wq_total < queue_limit && wq_total < DEPTH) begin
                        wq[wq_total] = make_entry(b.handle, b.tag, b.repeats, b.interval, 0);
                        wq_total++;
                    end else begin
                        r.dropped = 1'b1;
                        limit_hits[queue_limit] = 1;
                    end
                end
            end
            CMD_CLEAR: begin
                if (sh_valid && sh_tag == b.tag) begin
                    sh_repeats = REP_ONE;
                    r.action = ACT_ABORT;
                end
                i = 0;
                while (i < wq_total) begin
                    if (wq[i].tag == b.tag) drop_entry(i);
                    else i++;
                end
            end
            CMD_END: begin
                if (sh_valid) begin
                    rep = $signed(sh_repeats);
                    if (rep == -1 || rep - 1 > 0) begin
                        if (rep != -1) sh_repeats = sh_repeats - 8'd1;
                        if (wq_total == 0 && sh_interval == 0) begin
                            r.action = ACT_START; r.handle = sh_handle;
                            restarted = 1'b1;
                        end else begin
                            // requeue with timestamp; discard at full depth
                            if (wq_total < DEPTH) begin
                                wq[wq_total] = make_entry(sh_handle, sh_tag, sh_repeats,
                                                          sh_interval, b.now);
                                wq_total++;
                            end
                            sh_valid = 1'b0;
                        end
                    end else begin
                        sh_valid = 1'b0;
                    end
                end
                if (!restarted) pick_next(b.now, r);
            end
            CMD_EDGE:  r.action = ACT_ABORT;
            CMD_RETRY: pick_next(b.now, r);
            default: ;
        endcase
        r.count = wq_total[4:0];
        return r;
    endfunction

    function automatic msg_beat_t beat_of(logic [2:0] c, logic [7:0] h, logic [15:0] t,
                                          logic e, logic [7:0] rp, logic [15:0] iv,
                                          logic [31:0] nw);
        msg_beat_t b;
        b.cmd = c; b.handle = h; b.tag = t; b.empty = e;
        b.repeats = rp; b.interval = iv; b.now = nw;
        return b;
    endfunction

    // random beat: mostly well-formed traffic over a small tag set
    function automatic msg_beat_t random_beat();
        msg_beat_t b;
        int pick;
        b.handle = 8'($urandom_range(0, 255));
        b.empty = ($urandom_range(0, 5) == 0);
        pick = $urandom_range(0, 9);
        b.tag = (pick < 2) ? 16'd0 : (pick < 9) ? 16'($urandom_range(1, 6))
                                               : 16'($urandom);
        pick = $urandom_range(0, 9);
        b.repeats = (pick < 3) ? REP_FOREVER : (pick < 8) ? 8'($urandom_range(0, 4))
                                                          : 8'($urandom);
        pick = $urandom_range(0, 5);
        b.interval = (pick < 2) ? 16'd0 : (pick < 5) ? 16'($urandom_range(0, 3000))
                                                     : 16'($urandom);
        b.now = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 5000));
        pick = $urandom_range(0, 99);
        if (pick < 40)      b.cmd = CMD_NEW;
        else if (pick < 50) b.cmd = CMD_CLEAR;
        else if (pick < 78) b.cmd = CMD_END;
        else if (pick < 84) b.cmd = CMD_EDGE;
        else if (pick < 97) b.cmd = CMD_RETRY;
        else                b.cmd = 3'($urandom_range(5, 7));
        return b;
    endfunction

    // valid stays up into the next beat when no idle cycles are drawn
    task automatic send_beat(msg_beat_t b, bit typed, sched_result_t res);
        int idle;
        idle = $urandom_range(0, 13);
        if (idle != 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_cmd <= b.cmd; i_msg_handle <= b.handle; i_msg_tag <= b.tag;
        i_msg_empty <= b.empty; i_repeat_count <= b.repeats;
        i_interval_ms <= b.interval; i_now_ms <= b.now;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_beats++;
        typed_q.push_back(typed);
        typed_res_q.push_back(res);
        @(negedge i_clk);
    endtask

    // predict at the moment of acceptance, in beat order
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            pending_results.push_back(schedule(beat_of(i_cmd, i_msg_handle, i_msg_tag,
                                                       i_msg_empty, i_repeat_count,
                                                       i_interval_ms, i_now_ms)));
    end

    always @(posedge i_clk) begin
        sched_result_t want;
        sched_result_t typed_res;
        bit            is_typed;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat action=%0d", $time, o_action);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_action !== want.action || o_shown_handle !== want.handle ||
                    o_dropped !== want.dropped || o_queue_count !== want.count) begin
                    $display("%0t: expected act=%0d h=%0d drop=%0d cnt=%0d, got %0d %0d %0d %0d",
                             $time, want.action, want.handle, want.dropped, want.count,
                             o_action, o_shown_handle, o_dropped, o_queue_count);
                    errors++;
                end
            end
            if (typed_q.size() != 0) begin
                is_typed = typed_q.pop_front();
                typed_res = typed_res_q.pop_front();
                if (is_typed && (o_action !== typed_res.action ||
                                 o_shown_handle !== typed_res.handle ||
                                 o_dropped !== typed_res.dropped ||
                                 o_queue_count !== typed_res.count)) begin
                    $display("%0t: typed act=%0d h=%0d drop=%0d cnt=%0d, got %0d %0d %0d %0d",
                             $time, typed_res.action, typed_res.handle, typed_res.dropped,
                             typed_res.count, o_action, o_shown_handle, o_dropped,
                             o_queue_count);
                    errors++;
                end
            end
        end
    end

    // receiver: random stall per beat, or one long hold-off on request
    initial begin
        int wait_n;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_long) begin
                i_out_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                stall_long = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (wait_n == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                repeat (wait_n) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (2 * DEPTH + 10) @(negedge i_clk);
    endtask

    task automatic write_limit(int v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= 4'(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        queue_limit = v;
    endtask

    row_t rows[$];
    int   limits[6] = '{8, 1, 15, 0, 3, 15};

    initial begin
        sched_result_t blank;
        errors = 0; n_beats = 0; n_results = 0; stall_long = 1'b0;
        blank = '{ACT_NONE, 8'd0, 1'b0, 5'd0};
        wq_total = 0; sh_valid = 1'b0; sh_handle = 0; sh_tag = 0;
        sh_repeats = 0; sh_interval = 0; queue_limit = 8;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_data = 4'd0; i_in_valid = 1'b0;
        i_cmd = CMD_NEW; i_msg_handle = 0; i_msg_tag = 0; i_msg_empty = 0;
        i_repeat_count = 0; i_interval_ms = 0; i_now_ms = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows; results typed only where obvious
        rows.push_back('{beat_of(CMD_RETRY, 0, 0, 0, 0, 0, 0), 1, '{ACT_NONE, 0, 0, 0}});
        rows.push_back('{beat_of(CMD_END, 0, 0, 0, 0, 0, 0), 1, '{ACT_NONE, 0, 0, 0}});
        rows.push_back('{beat_of(CMD_NEW, 8'hFF, 16'hFFFF, 1, 8'h7F, 16'hFFFF, 32'hFFFFFFFF),
                         1, '{ACT_START, 8'hFF, 0, 0}});
        rows.push_back('{beat_of(CMD_EDGE, 0, 0, 0, 0, 0, 0), 1, '{ACT_ABORT, 0, 0, 0}});
        rows.push_back('{beat_of(3'd7, 8'h55, 16'h1, 0, 0, 0, 0), 1, '{ACT_NONE, 0, 0, 0}});
        rows.push_back('{beat_of(CMD_NEW, 8'h12, 16'hFFFF, 0, 8'h02, 0, 0),
                         1, '{ACT_SWAP, 8'h12, 0, 0}});
        rows.push_back('{beat_of(CMD_NEW, 8'h20, 0, 0, REP_FOREVER, 16'd100, 0), 0, '{default:0}});
        rows.push_back('{beat_of(CMD_NEW, 8'h21, 16'd7, 0, 8'h80, 16'd0, 0), 0, '{default:0}});
        rows.push_back('{beat_of(CMD_NEW, 8'h22, 16'd7, 0, 8'h03, 16'd0, 0), 0, '{default:0}});
        rows.push_back('{beat_of(CMD_END, 0, 0, 0, 0, 0, 32'd50), 0, '{default:0}});
        rows.push_back('{beat_of(CMD_END, 0, 0, 0, 0, 0, 32'd60), 0, '{default:0}});
        rows.push_back('{beat_of(CMD_RETRY, 0, 0, 0, 0, 0, 32'd5000), 0, '{default:0}});
        rows.push_back('{beat_of(CMD_CLEAR, 0, 16'd0, 0, 0, 0, 0), 0, '{default:0}});
        rows.push_back('{beat_of(CMD_NEW, 8'h30, 16'd9, 1, 0, 0, 0), 0, '{default:0}});
        rows.push_back('{beat_of(CMD_NEW, 8'h31, 16'd9, 1, 0, 0, 0), 0, '{default:0}});
        rows.push_back('{beat_of(CMD_CLEAR, 0, 16'd9, 0, 0, 0, 0), 0, '{default:0}});
        rows.push_back('{beat_of(CMD_END, 0, 0, 0, 0, 0, 32'hFFFFFFF0), 0, '{default:0}});
        rows.push_back('{beat_of(CMD_RETRY, 0, 0, 0, 0, 0, 32'h10), 0, '{default:0}});
        rows.push_back('{beat_of(CMD_NEW, 8'h40, 16'd3, 0, 8'h00, 16'd0, 0), 0, '{default:0}});
        rows.push_back('{beat_of(CMD_END, 0, 0, 0, 0, 0, 32'd1), 0, '{default:0}});

        foreach (rows[i]) send_beat(rows[i].beat, rows[i].typed, rows[i].res);
        drain();

        // random phases across queue limits, extremes included
        foreach (limits[p]) begin
            write_limit(limits[p]);
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                if (p == 2 && n == 20) stall_long = 1'b1;
                send_beat(random_beat(), 1'b0, blank);
            end
            drain();
        end

        $display("covered %0d beats, %0d results, queue limits 0..15 incl. extremes",
                 n_beats, n_results);
        $display("limit drops seen under %0d distinct limit settings", limit_hits.num());
        if (errors == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
